// File: hdl/twc_pkg.sv
package twc_pkg;

  // Fixed field widths.
  localparam int TS_W      = 64;
  localparam int WSEC_W    = 32;
  localparam int SEC_MAG_W = 44;
  localparam int STEP_W    = 7;

  // Microseconds per second, used to scale the window start back up.
  localparam logic [19:0] US_PER_SEC = 20'd1000000;

  // Division of the timestamp by one million: a shift by six, then 16-bit
  // chunks divided by 15625, each through a multiplication by its reciprocal.
  // The reciprocal is exact for every chunk value below 2^30.
  localparam int SEC_SHIFT = 6;
  localparam int CHUNK_W   = 16;
  localparam int SEC_REM_W = 14;
  localparam int RCP_W     = 31;
  localparam int RCP_SHIFT = 44;
  localparam logic [SEC_REM_W-1:0] SEC_DIV = 14'd15625;
  localparam logic [RCP_W-1:0]     RCP_MUL = 31'd1125899907;

  // Step counts: chunks of the seconds division, then bits of the window remainder.
  localparam logic [STEP_W-1:0] SEC_CHUNKS = 7'd4;
  localparam logic [STEP_W-1:0] WIN_STEPS  = 7'd44;

  // Reset value of the window length register.
  localparam logic [WSEC_W-1:0] WSEC_RESET = 32'd86400;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_in;
    logic sec_mul;
    logic sec_sub;
    logic load_win;
    logic div_step;
    logic mul;
    logic fix;
    logic scan_clr;
    logic scan_en;
    logic wr_append;
    logic wr_swap;
    logic wr_front;
    logic res_win;
    logic res_best;
    logic out_load;
  } twc_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic div_done;
    logic scan_done;
    logic hit;
    logic full;
  } twc_status_t;

endpackage

// File: hdl/time_window_classifier_unit.sv
// Classifies signed microsecond timestamps into time windows. Each transaction
// on the input channel yields exactly one transaction on the output channel: the
// window start (seconds truncated toward zero, minus their remainder modulo
// window_seconds, scaled back to microseconds), or, when the window table is
// full and holds no match, the stored window nearest to it. Items are processed
// one at a time. The division by one million is a shift by six, then four
// 16-bit chunks divided by 15625 through reciprocal multiplication, each in a
// multiply state and a subtract state. The bit-serial remainder modulo the
// window length follows, then scaling and sign restore. The table scan reads
// one entry per cycle; then the table is updated and the output register is
// loaded once it is free. A finished result is held in an output register,
// so the next item is taken while it waits. A window length of zero acts as
// one second. The table needs no clearing after reset.
module time_window_classifier_unit #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [twc_pkg::WSEC_W-1:0]          cfg_wdata,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [twc_pkg::TS_W-1:0]     timestamp_us,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [twc_pkg::TS_W-1:0]     window_start_us
);

  twc_pkg::twc_cmd_t    cmd;
  twc_pkg::twc_status_t status;

  // Sequencer.
  twc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // Dividers, window arithmetic and table.
  twc_dpath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dpath (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .timestamp_us    (timestamp_us),
    .cmd             (cmd),
    .status          (status),
    .window_start_us (window_start_us)
  );

endmodule

// File: hdl/twc_dpath.sv
module twc_dpath #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [twc_pkg::WSEC_W-1:0]  cfg_wdata,
  input  logic signed [twc_pkg::TS_W-1:0] timestamp_us,
  input  twc_pkg::twc_cmd_t           cmd,
  output twc_pkg::twc_status_t        status,
  output logic signed [twc_pkg::TS_W-1:0] window_start_us
);

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int TS_W  = twc_pkg::TS_W;
  localparam int WS_W  = twc_pkg::WSEC_W;
  localparam int SM_W  = twc_pkg::SEC_MAG_W;
  localparam int CH_W  = twc_pkg::CHUNK_W;
  localparam int REM_W = twc_pkg::SEC_REM_W;
  localparam int RV_W  = REM_W + CH_W;
  localparam int PR_W  = RV_W + twc_pkg::RCP_W;

  logic [WS_W-1:0]   window_seconds;

  // Chunked division of the timestamp magnitude by one million.
  logic [TS_W-1:0]   sec_dvd;
  logic [REM_W-1:0]  sec_rem;
  logic [SM_W-1:0]   sec_quo;
  logic [CH_W-1:0]   chunk_q;
  logic [RV_W-1:0]   chunk_v;
  logic [PR_W-1:0]   rcp_prod;
  logic [RV_W-1:0]   chunk_rem;

  // Bit-serial divider for the window remainder.
  logic [TS_W-1:0]   dvd;
  logic [WS_W-1:0]   dvs;
  logic [WS_W-1:0]   rem;
  logic [twc_pkg::STEP_W-1:0] step_cnt;
  logic [WS_W:0]     trial;
  logic [WS_W:0]     trial_sub;
  logic              trial_ge;

  // Window arithmetic.
  logic              neg;
  logic [SM_W-1:0]   sec_mag;
  logic [SM_W-1:0]   base_mag;
  logic [TS_W-1:0]   prod_full;
  logic [TS_W-1:0]   prod;
  logic [TS_W-1:0]   win;
  logic [TS_W-1:0]   ts_mag;

  // Table scan.
  logic [TS_W-1:0]   mem [TABLE_DEPTH];
  logic [TS_W-1:0]   rd_data;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  rd_idx;
  logic [IDX_W-1:0]  cmp_idx;
  logic              cmp_vld;
  logic              hit;
  logic [IDX_W-1:0]  hit_idx;
  logic [TS_W-1:0]   entry0;
  logic [TS_W-1:0]   best;
  logic [TS_W-1:0]   best_diff;
  logic [TS_W:0]     diff_s;
  logic [TS_W-1:0]   diff_mag;
  logic              issue;
  logic [TS_W-1:0]   res;

  // Memory write port.
  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  logic [TS_W-1:0]   wr_data;

  // Magnitude of the incoming timestamp; the most negative value maps to 2^63.
  assign ts_mag = timestamp_us[TS_W-1] ? (~timestamp_us + 1'b1) : timestamp_us;

  // One chunk of the seconds division: quotient by reciprocal, then remainder.
  assign chunk_v   = {sec_rem, sec_dvd[TS_W-1 -: CH_W]};
  assign rcp_prod  = PR_W'(chunk_v) * PR_W'(twc_pkg::RCP_MUL);
  assign chunk_rem = chunk_v - RV_W'(chunk_q) * RV_W'(twc_pkg::SEC_DIV);

  // One restoring division step.
  assign trial     = {rem, dvd[TS_W-1]};
  assign trial_sub = trial - {1'b0, dvs};
  assign trial_ge  = (trial >= {1'b0, dvs});

  // Window magnitude in seconds, then scaled to microseconds.
  assign base_mag  = sec_mag - SM_W'(rem);
  assign prod_full = TS_W'(base_mag) * TS_W'(twc_pkg::US_PER_SEC);

  // Absolute difference of the entry being compared and the window, over 65 bits.
  assign diff_s   = {rd_data[TS_W-1], rd_data} - {win[TS_W-1], win};
  assign diff_mag = diff_s[TS_W] ? TS_W'(~diff_s + 1'b1) : diff_s[TS_W-1:0];

  assign issue = cmd.scan_en && !hit && (rd_idx < count);

  // Write port selection.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = win;
    if (cmd.wr_append) begin
      wr_en   = 1'b1;
      wr_addr = count[IDX_W-1:0];
    end else if (cmd.wr_swap) begin
      wr_en   = 1'b1;
      wr_addr = hit_idx;
      wr_data = entry0;
    end else if (cmd.wr_front) begin
      wr_en   = 1'b1;
    end
  end

  // Window table storage with registered read.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (issue) begin
      rd_data <= mem[rd_idx[IDX_W-1:0]];
    end
  end

  // Configuration register and table fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      window_seconds <= twc_pkg::WSEC_RESET;
      count          <= '0;
    end else begin
      if (cfg_we) begin
        window_seconds <= cfg_wdata;
      end
      if (cmd.wr_append) begin
        count <= count + 1'b1;
      end
    end
  end

  // Step counter and scan control flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      step_cnt <= '0;
      rd_idx   <= '0;
      cmp_vld  <= 1'b0;
      hit      <= 1'b0;
    end else begin
      if (cmd.load_in) begin
        step_cnt <= twc_pkg::SEC_CHUNKS;
      end else if (cmd.load_win) begin
        step_cnt <= twc_pkg::WIN_STEPS;
      end else if ((cmd.div_step || cmd.sec_sub) && step_cnt != '0) begin
        step_cnt <= step_cnt - 1'b1;
      end

      if (cmd.scan_clr) begin
        rd_idx  <= '0;
        cmp_vld <= 1'b0;
        hit     <= 1'b0;
      end else if (cmd.scan_en) begin
        cmp_vld <= issue;
        if (issue) begin
          rd_idx <= rd_idx + 1'b1;
        end
        if (cmp_vld && !hit && rd_data == win) begin
          hit <= 1'b1;
        end
      end
    end
  end

  // Datapath payload registers.
  always_ff @(posedge clk) begin
    // Seconds: the magnitude shifted down by six, divided by 15625 a chunk at a time.
    if (cmd.load_in) begin
      sec_dvd <= ts_mag >> twc_pkg::SEC_SHIFT;
      sec_rem <= '0;
      sec_quo <= '0;
      neg     <= timestamp_us[TS_W-1];
    end else if (cmd.sec_mul) begin
      chunk_q <= rcp_prod[twc_pkg::RCP_SHIFT+CH_W-1:twc_pkg::RCP_SHIFT];
    end else if (cmd.sec_sub) begin
      sec_rem <= chunk_rem[REM_W-1:0];
      sec_dvd <= sec_dvd << CH_W;
      sec_quo <= {sec_quo[SM_W-CH_W-1:0], chunk_q};
    end

    // Remainder of the seconds modulo the window length.
    if (cmd.load_win) begin
      sec_mag <= sec_quo;
      dvd     <= {sec_quo, {(TS_W-SM_W){1'b0}}};
      dvs     <= (window_seconds == '0) ? WS_W'(1) : window_seconds;
      rem     <= '0;
    end else if (cmd.div_step && step_cnt != '0) begin
      rem <= trial_ge ? trial_sub[WS_W-1:0] : trial[WS_W-1:0];
      dvd <= {dvd[TS_W-2:0], 1'b0};
    end

    // Scale and restore the sign.
    if (cmd.mul) begin
      prod <= prod_full;
    end
    if (cmd.fix) begin
      win <= neg ? (~prod + 1'b1) : prod;
    end

    // Compare the entry read in the previous cycle.
    if (cmd.scan_en && cmp_vld) begin
      if (!hit && rd_data == win) begin
        hit_idx <= cmp_idx;
      end
      if (cmp_idx == '0) begin
        entry0    <= rd_data;
        best      <= rd_data;
        best_diff <= diff_mag;
      end else if (diff_mag < best_diff) begin
        best      <= rd_data;
        best_diff <= diff_mag;
      end
    end
    if (issue) begin
      cmp_idx <= rd_idx[IDX_W-1:0];
    end

    // Result selection and output register.
    if (cmd.res_win) begin
      res <= win;
    end else if (cmd.res_best) begin
      res <= best;
    end
    if (cmd.out_load) begin
      window_start_us <= res;
    end
  end

  assign status.div_done  = (step_cnt == '0);
  assign status.scan_done = !cmp_vld && (hit || rd_idx == count);
  assign status.hit       = hit;
  assign status.full      = (count == CNT_W'(TABLE_DEPTH));

endmodule

// File: hdl/twc_ctrl.sv
module twc_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  twc_pkg::twc_status_t status,
  output twc_pkg::twc_cmd_t    cmd
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SEC_MUL,
    ST_SEC_SUB,
    ST_DIV_WIN,
    ST_MUL,
    ST_FIX,
    ST_SCAN,
    ST_SWAP,
    ST_FRONT,
    ST_DONE
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == ST_IDLE);

  // Command decode and next state.
  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = ST_SEC_MUL;
        end
      end
      ST_SEC_MUL: begin
        if (status.div_done) begin
          cmd.load_win = 1'b1;
          state_next   = ST_DIV_WIN;
        end else begin
          cmd.sec_mul = 1'b1;
          state_next  = ST_SEC_SUB;
        end
      end
      ST_SEC_SUB: begin
        cmd.sec_sub = 1'b1;
        state_next  = ST_SEC_MUL;
      end
      ST_DIV_WIN: begin
        cmd.div_step = 1'b1;
        if (status.div_done) begin
          state_next = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul    = 1'b1;
        state_next = ST_FIX;
      end
      ST_FIX: begin
        cmd.fix      = 1'b1;
        cmd.scan_clr = 1'b1;
        state_next   = ST_SCAN;
      end
      ST_SCAN: begin
        cmd.scan_en = 1'b1;
        if (status.scan_done) begin
          if (status.hit) begin
            cmd.res_win = 1'b1;
            state_next  = ST_SWAP;
          end else if (!status.full) begin
            cmd.res_win   = 1'b1;
            cmd.wr_append = 1'b1;
            state_next    = ST_DONE;
          end else begin
            cmd.res_best = 1'b1;
            state_next   = ST_DONE;
          end
        end
      end
      ST_SWAP: begin
        cmd.wr_swap = 1'b1;
        state_next  = ST_FRONT;
      end
      ST_FRONT: begin
        cmd.wr_front = 1'b1;
        state_next   = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid || out_ready) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // State and output valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

  localparam int TABLE_DEPTH = 16;
  localparam longint USEC = 1000000;
  localparam int PHASES = 8;
  localparam int ITEMS_PER_PHASE = 230;

  // Kinds of rows in the directed stimulus table.
  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_e;

  typedef struct packed {
    row_kind_e   kind;
    logic [31:0] cfg_val;
    logic [63:0] ts;
    logic        has_lit;
    logic [63:0] lit;
  } dir_row_t;

  // Directed rows. Window length is 86400 s until the first register write.
  // The eight rows after the second write of 1 s fill the window table.
  localparam dir_row_t DIRECTED_ROWS [25] = '{
    '{ROW_ITEM, 32'd0, 64'sd0, 1'b1, 64'sd0},
    '{ROW_ITEM, 32'd0, -64'sd1, 1'b1, 64'sd0},
    '{ROW_ITEM, 32'd0, 64'sd86400000005, 1'b1, 64'sd86400000000},
    '{ROW_CFG, 32'd0, 64'sd0, 1'b0, 64'sd0},
    '{ROW_ITEM, 32'd0, 64'sd1500000, 1'b1, 64'sd1000000},
    '{ROW_ITEM, 32'd0, -64'sd1500000, 1'b1, -64'sd1000000},
    '{ROW_ITEM, 32'd0, 64'h7FFF_FFFF_FFFF_FFFF, 1'b1, 64'sd9223372036854000000},
    '{ROW_ITEM, 32'd0, 64'h8000_0000_0000_0000, 1'b1, -64'sd9223372036854000000},
    '{ROW_CFG, 32'hFFFF_FFFF, 64'sd0, 1'b0, 64'sd0},
    '{ROW_ITEM, 32'd0, 64'h7FFF_FFFF_FFFF_FFFF, 1'b0, 64'sd0},
    '{ROW_ITEM, 32'd0, 64'h8000_0000_0000_0000, 1'b0, 64'sd0},
    '{ROW_CFG, 32'd1, 64'sd0, 1'b0, 64'sd0},
    '{ROW_ITEM, 32'd0, 64'sd999999, 1'b1, 64'sd0},
    '{ROW_ITEM, 32'd0, -64'sd999999, 1'b1, 64'sd0},
    '{ROW_ITEM, 32'd0, 64'sd2000123, 1'b1, 64'sd2000000},
    '{ROW_ITEM, 32'd0, 64'sd4000456, 1'b1, 64'sd4000000},
    '{ROW_ITEM, 32'd0, 64'sd6000789, 1'b1, 64'sd6000000},
    '{ROW_ITEM, 32'd0, 64'sd8000001, 1'b1, 64'sd8000000},
    '{ROW_ITEM, 32'd0, 64'sd10999999, 1'b1, 64'sd10000000},
    '{ROW_ITEM, 32'd0, 64'sd12000000, 1'b1, 64'sd12000000},
    '{ROW_ITEM, 32'd0, 64'sd14500000, 1'b1, 64'sd14000000},
    '{ROW_ITEM, 32'd0, 64'sd16000002, 1'b1, 64'sd16000000},
    '{ROW_ITEM, 32'd0, 64'sd3500000, 1'b0, 64'sd0},
    '{ROW_ITEM, 32'd0, 64'sd4000001, 1'b1, 64'sd4000000},
    '{ROW_ITEM, 32'd0, -64'sd5000000, 1'b0, 64'sd0}
  };

  // Window lengths used by the random phases; index 5 is drawn at random.
  localparam logic [31:0] PHASE_LENGTHS [PHASES] = '{
    32'd1, 32'd0, 32'd60, 32'hFFFF_FFFF, 32'd86400, 32'd0, 32'd3600, 32'd7
  };

  logic               clk;
  logic               rst;
  logic               cfg_we;
  logic [31:0]        cfg_wdata;
  logic               in_valid;
  logic               in_ready;
  logic signed [63:0] timestamp_us;
  logic               out_valid;
  logic               out_ready;
  logic signed [63:0] window_start_us;

  // Literal expectation that travels with the transaction being offered.
  logic   lit_valid;
  longint lit_value;

  // Predictor state.
  logic [31:0] win_len;
  longint      win_table [TABLE_DEPTH];
  int          win_fill;
  longint      pending_starts[$];

  int mismatch_count;
  int tx_idle_max;
  int rx_idle_max;

  time_window_classifier_unit #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .timestamp_us(timestamp_us),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .window_start_us(window_start_us)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #30_000_000;
    $display("status: fail");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    mismatch_count++;
  endtask

  // Window start: seconds truncated toward zero, minus their truncating
  // remainder modulo the window length, scaled back to microseconds.
  function automatic longint calc_window_start(input longint ts);
    longint w;
    longint sec;
    w = (win_len == 32'd0) ? 64'sd1 : longint'({32'd0, win_len});
    sec = ts / USEC;
    return (sec - sec % w) * USEC;
  endfunction

  // Absolute difference over 65 bits so that it never overflows.
  function automatic logic [64:0] abs_gap(input longint a, input longint b);
    logic [64:0] d;
    d = {a[63], a} - {b[63], b};
    return d[64] ? (~d + 65'd1) : d;
  endfunction

  // Looks the window up in the table, updating the table as the block does.
  function automatic longint classify_window(input longint ts);
    longint      win;
    longint      best;
    logic [64:0] best_gap;
    logic [64:0] g;
    win = calc_window_start(ts);
    for (int i = 0; i < win_fill; i++) begin
      if (win_table[i] == win) begin
        win_table[i] = win_table[0];
        win_table[0] = win;
        return win;
      end
    end
    if (win_fill < TABLE_DEPTH) begin
      win_table[win_fill] = win;
      win_fill++;
      return win;
    end
    // Table full and no match: nearest entry, the earliest one on a tie.
    best = win_table[0];
    best_gap = abs_gap(win_table[0], win);
    for (int i = 1; i < TABLE_DEPTH; i++) begin
      g = abs_gap(win_table[i], win);
      if (g < best_gap) begin
        best_gap = g;
        best = win_table[i];
      end
    end
    return best;
  endfunction

  // Checks each result transaction, then records the expectation for each
  // accepted input transaction and tracks register writes.
  always @(posedge clk) begin : monitor
    longint want;
    if (rst) begin
      win_len = twc_pkg::WSEC_RESET;
      win_fill = 0;
      foreach (win_table[i]) win_table[i] = 0;
      pending_starts.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (pending_starts.size() == 0) begin
          report_mismatch($sformatf("unexpected window start %0d", window_start_us));
        end else begin
          want = pending_starts.pop_front();
          if (window_start_us !== want) begin
            report_mismatch($sformatf("window start %0d, expected %0d",
                                      window_start_us, want));
          end
        end
      end
      if (in_valid && in_ready) begin
        want = classify_window(timestamp_us);
        pending_starts = {pending_starts, (lit_valid ? lit_value : want)};
      end
      if (cfg_we) begin
        win_len = cfg_wdata;
      end
    end
  end

  // Result side: a random stall before each transaction.
  initial begin : result_sink
    int n;
    out_ready <= 1'b0;
    wait (rst === 1'b0);
    forever begin
      n = $urandom_range(0, rx_idle_max);
      if (n > 0) begin
        out_ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Offers one timestamp after a random gap and waits until it is taken.
  task automatic send_timestamp(input longint ts, input logic has_lit, input longint lit);
    int n;
    n = $urandom_range(0, tx_idle_max);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    in_valid <= 1'b1;
    timestamp_us <= ts;
    lit_valid <= has_lit;
    lit_value <= lit;
    do @(posedge clk); while (!in_ready);
  endtask

  // Stops sending and waits until every expected result has come.
  task automatic finish_pending();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_starts.size() != 0) @(posedge clk);
  endtask

  task automatic write_window(input logic [31:0] len);
    finish_pending();
    repeat (8) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= len;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin : stimulus
    longint      ts;
    longint      e;
    longint      f;
    int          mode;
    logic [31:0] len;
    mismatch_count = 0;
    tx_idle_max = 5;
    rx_idle_max = 5;
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_wdata <= '0;
    in_valid <= 1'b0;
    timestamp_us <= '0;
    lit_valid <= 1'b0;
    lit_value <= 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part: extremes, zero and widest window, hits, ties, full table.
    foreach (DIRECTED_ROWS[r]) begin
      if (DIRECTED_ROWS[r].kind == ROW_CFG) begin
        write_window(DIRECTED_ROWS[r].cfg_val);
      end else begin
        send_timestamp(DIRECTED_ROWS[r].ts, DIRECTED_ROWS[r].has_lit, DIRECTED_ROWS[r].lit);
      end
    end

    // Random phases, each under its own window length. Every third phase
    // runs without idle cycles on either side.
    for (int p = 0; p < PHASES; p++) begin
      len = (p == 5) ? $urandom : PHASE_LENGTHS[p];
      write_window(len);
      tx_idle_max = (p % 3 == 2) ? 0 : 5;
      rx_idle_max = (p % 3 == 2) ? 0 : 5;
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        mode = $urandom_range(0, 99);
        if (mode < 50) begin
          // Close to a known window, mostly a hit.
          e = win_table[$urandom_range(0, TABLE_DEPTH - 1)];
          f = longint'($urandom_range(0, 775807));
          ts = (e >= 0) ? e + f : e - f;
        end else if (mode < 70) begin
          // Halfway between two known windows, a candidate for a tie.
          e = win_table[$urandom_range(0, TABLE_DEPTH - 1)];
          f = win_table[$urandom_range(0, TABLE_DEPTH - 1)];
          ts = (e >>> 1) + (f >>> 1);
        end else if (mode < 85) begin
          ts = longint'($urandom_range(0, 100_000_000)) - 64'sd50_000_000;
        end else begin
          ts = {$urandom, $urandom};
        end
        send_timestamp(ts, 1'b0, 0);
      end
    end

    finish_pending();
    repeat (200) @(posedge clk);
    if (mismatch_count == 0 && pending_starts.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// File: files.f
hdl/twc_pkg.sv
hdl/twc_dpath.sv
hdl/twc_ctrl.sv
hdl/time_window_classifier_unit.sv
bench/tb_top.sv
